// File: hw/rtl/hotp_pkg.sv
`timescale 1ns / 1ps

package hotp_pkg;

  // Fixed geometry of the digest and of the decimal conversion.
  localparam int DIGEST_BYTES       = 20;
  localparam int WIN_BITS           = 31;
  localparam int BCD_DIGITS         = 10;
  localparam int BCD_BITS           = 4 * BCD_DIGITS;
  localparam int DD_STEPS_PER_STAGE = 4;
  localparam int DD_STAGES          = (WIN_BITS + DD_STEPS_PER_STAGE - 1) / DD_STEPS_PER_STAGE;
  localparam int MAX_DIGITS         = 9;
  localparam int CODE_BITS          = 34;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CODE_DIGITS  = 2'd0,
    CFG_ADD_CHECK    = 2'd1,
    CFG_FIXED_OFFSET = 2'd2
  } cfg_idx_t;

  // Settings that the code stages read.
  typedef struct packed {
    logic [3:0] code_digits;
    logic       add_check;
  } code_cfg_t;

  // Transfer from the window select stage into the decimal converter.
  typedef struct packed {
    logic                valid;
    logic [WIN_BITS-1:0] window;
  } win_beat_t;

  // Transfer from the decimal converter into the code stages.
  typedef struct packed {
    logic                valid;
    logic [BCD_BITS-1:0] bcd;
    logic [WIN_BITS-1:0] window;
  } bcd_beat_t;

  // One shift-and-add-3 step: correct each digit, then shift the binary MSB in.
  function automatic logic [BCD_BITS+WIN_BITS-1:0] dd_step(input logic [BCD_BITS-1:0] bcd,
                                                            input logic [WIN_BITS-1:0] bin);
    logic [BCD_BITS-1:0] adj;
    adj = bcd;
    for (int j = 0; j < BCD_DIGITS; j++) begin
      if (adj[4*j +: 4] >= 4'd5) begin
        adj[4*j +: 4] = adj[4*j +: 4] + 4'd3;
      end
    end
    return {adj[BCD_BITS-2:0], bin, 1'b0};
  endfunction

  // Doubled digit with the tens folded back in.
  function automatic logic [3:0] dbl_digit(input logic [3:0] d);
    logic [3:0] r;
    case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      4'd9:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Five BCD digits to binary by Horner steps.
  function automatic logic [16:0] bcd5_to_bin(input logic [19:0] d);
    logic [16:0] acc;
    acc = 17'd0;
    for (int k = 4; k >= 0; k--) begin
      acc = 17'(acc * 17'd10) + 17'(d[4*k +: 4]);
    end
    return acc;
  endfunction

endpackage

// File: hw/rtl/hotp_window.sv
`timescale 1ns / 1ps

module hotp_window (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [63:0]           digest_top,
  input  logic [63:0]           digest_middle,
  input  logic [31:0]           digest_bottom,
  input  logic [4:0]            fixed_offset,
  output hotp_pkg::win_beat_t   beat_out
);

  logic [8*hotp_pkg::DIGEST_BYTES-1:0] digest;
  logic [3:0]                          offset;
  logic [7:0]                          base;
  logic [31:0]                         raw;
  hotp_pkg::win_beat_t                 beat_r;
  hotp_pkg::win_beat_t                 beat_nxt;

  // Byte 0 of the digest sits in the top bits.
  assign digest = {digest_top, digest_middle, digest_bottom};

  // A negative fixed offset falls back to the low nibble of the last byte.
  assign offset = fixed_offset[4] ? digest[3:0] : fixed_offset[3:0];

  // Window byte k starts 8*k bits below the top of the digest.
  assign base = 8'd128 - {1'b0, offset, 3'b000};
  assign raw  = digest[base +: 32];

  always_comb begin
    beat_nxt.valid  = accept;
    beat_nxt.window = raw[hotp_pkg::WIN_BITS-1:0];
  end

  // Valid is cleared by reset; the window needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= beat_nxt.valid;
    end
    beat_r.window <= beat_nxt.window;
  end

  assign beat_out = beat_r;

endmodule

// File: hw/rtl/hotp_bcd.sv
`timescale 1ns / 1ps

module hotp_bcd (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hotp_pkg::win_beat_t  beat_in,
  output hotp_pkg::bcd_beat_t  beat_out
);

  localparam int NS = hotp_pkg::DD_STAGES;
  localparam int BB = hotp_pkg::BCD_BITS;
  localparam int WB = hotp_pkg::WIN_BITS;

  logic          valid_r [NS];
  logic [BB-1:0] bcd_r   [NS];
  logic [WB-1:0] bin_r   [NS];
  logic [WB-1:0] win_r   [NS];

  genvar s;
  generate
    for (s = 0; s < NS; s++) begin : g_stage
      logic          valid_in;
      logic [BB-1:0] bcd_in;
      logic [WB-1:0] bin_in;
      logic [WB-1:0] win_in;
      logic [BB-1:0] bcd_nxt;
      logic [WB-1:0] bin_nxt;

      // Stage zero starts the conversion from an empty BCD word.
      if (s == 0) begin : g_first
        assign valid_in = beat_in.valid;
        assign bcd_in   = '0;
        assign bin_in   = beat_in.window;
        assign win_in   = beat_in.window;
      end else begin : g_next
        assign valid_in = valid_r[s-1];
        assign bcd_in   = bcd_r[s-1];
        assign bin_in   = bin_r[s-1];
        assign win_in   = win_r[s-1];
      end

      // A few conversion steps per stage; the last stage does what is left.
      always_comb begin
        logic [BB+WB-1:0] st;
        st = {bcd_in, bin_in};
        for (int k = 0; k < hotp_pkg::DD_STEPS_PER_STAGE; k++) begin
          if (s * hotp_pkg::DD_STEPS_PER_STAGE + k < WB) begin
            st = hotp_pkg::dd_step(st[BB+WB-1:WB], st[WB-1:0]);
          end
        end
        bcd_nxt = st[BB+WB-1:WB];
        bin_nxt = st[WB-1:0];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[s] <= 1'b0;
        end else begin
          valid_r[s] <= valid_in;
        end
        bcd_r[s] <= bcd_nxt;
        bin_r[s] <= bin_nxt;
        win_r[s] <= win_in;
      end
    end
  endgenerate

  always_comb begin
    beat_out.valid  = valid_r[NS-1];
    beat_out.bcd    = bcd_r[NS-1];
    beat_out.window = win_r[NS-1];
  end

endmodule

// File: hw/rtl/hotp_code.sv
`timescale 1ns / 1ps

module hotp_code (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hotp_pkg::code_cfg_t   cfg,
  input  hotp_pkg::bcd_beat_t   beat_in,
  output logic                  out_valid,
  output logic [33:0]           out_code,
  output logic [30:0]           out_window
);

  localparam int KB = 4 * hotp_pkg::MAX_DIGITS;

  // Stage A registers: kept digits and the check sum.
  logic          a_valid_r;
  logic [KB-1:0] a_digits_r;
  logic [KB-1:0] a_digits_nxt;
  logic [6:0]    a_total_r;
  logic [6:0]    a_total_nxt;
  logic [30:0]   a_win_r;

  // Stage B registers: binary halves of the final code.
  logic          b_valid_r;
  logic [16:0]   b_lo_r;
  logic [16:0]   b_lo_nxt;
  logic [16:0]   b_hi_r;
  logic [16:0]   b_hi_nxt;
  logic [30:0]   b_win_r;

  // Stage C registers: the result.
  logic          c_valid_r;
  logic [33:0]   c_code_r;
  logic [33:0]   c_code_nxt;
  logic [30:0]   c_win_r;

  logic [3:0]    n_digits;
  logic [17:0]   quot_prod;
  logic [3:0]    quot;
  logic [3:0]    rem;
  logic [3:0]    check;
  logic [39:0]   code_bcd;

  // Digit counts above nine saturate.
  assign n_digits = (cfg.code_digits > 4'(hotp_pkg::MAX_DIGITS))
                  ? 4'(hotp_pkg::MAX_DIGITS) : cfg.code_digits;

  // Keep the low digits and sum them, doubling the rightmost and every other.
  always_comb begin
    logic [3:0] d;
    a_digits_nxt = '0;
    a_total_nxt  = 7'd0;
    for (int i = 0; i < hotp_pkg::MAX_DIGITS; i++) begin
      d = beat_in.bcd[4*i +: 4];
      if (4'(i) < n_digits) begin
        a_digits_nxt[4*i +: 4] = d;
        a_total_nxt = a_total_nxt + 7'(((i % 2) == 0) ? hotp_pkg::dbl_digit(d) : d);
      end
    end
  end

  // Sum modulo ten by a reciprocal multiply; exact for sums this small.
  assign quot_prod = 18'(a_total_r) * 18'd205;
  assign quot      = quot_prod[14:11];
  assign rem       = 4'(a_total_r - 7'(quot) * 7'd10);
  assign check     = (rem == 4'd0) ? 4'd0 : 4'(4'd10 - rem);

  // The check digit shifts the kept digits up by one place.
  assign code_bcd = cfg.add_check ? {a_digits_r, check} : {4'd0, a_digits_r};
  assign b_lo_nxt = hotp_pkg::bcd5_to_bin(code_bcd[19:0]);
  assign b_hi_nxt = hotp_pkg::bcd5_to_bin(code_bcd[39:20]);

  assign c_code_nxt = 34'(34'(b_hi_r) * 34'd100000) + 34'(b_lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= beat_in.valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
    a_digits_r <= a_digits_nxt;
    a_total_r  <= a_total_nxt;
    a_win_r    <= beat_in.window;
    b_lo_r     <= b_lo_nxt;
    b_hi_r     <= b_hi_nxt;
    b_win_r    <= a_win_r;
    c_code_r   <= c_code_nxt;
    c_win_r    <= b_win_r;
  end

  assign out_valid  = c_valid_r;
  assign out_code   = c_code_r;
  assign out_window = c_win_r;

endmodule

// File: hw/rtl/hotp_code_from_digest.sv
`timescale 1ns / 1ps

// Channel   Ports                                        Transfer
// input     start, busy, in_digest_*                     start high while busy low
// result    out_valid, out_code_value, out_window_value  out_valid high for one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid and cfg_ready high
//
// One digest enters every cycle; each result passes through 1 window stage,
// 8 binary-to-decimal stages and 3 code stages on its way to the ports.
// busy stays low: the results cannot be held off, so the pipeline never stalls.
// Synchronous active-low reset clears the valid bits and loads the register defaults.

module hotp_code_from_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_digest_top,
  input  logic [63:0] in_digest_middle,
  input  logic [31:0] in_digest_bottom,
  output logic        out_valid,
  output logic [33:0] out_code_value,
  output logic [30:0] out_window_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  logic [3:0]          code_digits_r;
  logic                add_check_r;
  logic [4:0]          fixed_offset_r;
  hotp_pkg::code_cfg_t code_cfg;
  hotp_pkg::win_beat_t win_beat;
  hotp_pkg::bcd_beat_t bcd_beat;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_digits_r  <= 4'd6;
      add_check_r    <= 1'b0;
      fixed_offset_r <= 5'h1F;
    end else if (cfg_valid && cfg_ready) begin
      case (hotp_pkg::cfg_idx_t'(cfg_index))
        hotp_pkg::CFG_CODE_DIGITS:  code_digits_r  <= cfg_data[3:0];
        hotp_pkg::CFG_ADD_CHECK:    add_check_r    <= cfg_data[0];
        hotp_pkg::CFG_FIXED_OFFSET: fixed_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign code_cfg.code_digits = code_digits_r;
  assign code_cfg.add_check   = add_check_r;

  // Window selection.
  hotp_window u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (start && !busy),
    .digest_top    (in_digest_top),
    .digest_middle (in_digest_middle),
    .digest_bottom (in_digest_bottom),
    .fixed_offset  (fixed_offset_r),
    .beat_out      (win_beat)
  );

  // Binary to decimal conversion.
  hotp_bcd u_bcd (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_in  (win_beat),
    .beat_out (bcd_beat)
  );

  // Digit masking, check digit and final code.
  hotp_code u_code (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (code_cfg),
    .beat_in    (bcd_beat),
    .out_valid  (out_valid),
    .out_code   (out_code_value),
    .out_window (out_window_value)
  );

endmodule

// File: hw/rtl/hotp_checker.sv
`timescale 1ns / 1ps

module hotp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [33:0] out_code_value,
  input logic [30:0] out_window_value,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [4:0]  cfg_data
);

  logic       chk_on_r;
  logic [3:0] digits_r;

  // Shadow of the settings, rebuilt from configuration transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_on_r <= 1'b0;
      digits_r <= 4'd6;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == hotp_pkg::CFG_ADD_CHECK) begin
        chk_on_r <= cfg_data[0];
      end
      if (cfg_index == hotp_pkg::CFG_CODE_DIGITS) begin
        digits_r <= cfg_data[3:0];
      end
    end
  end

  // The pipeline can never stall.
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // A code never exceeds ten decimal digits.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_code_value <= 34'd9999999999)
    else $error("code out of range");

  // Without a check digit the code is a remainder of the window, so it never exceeds the window.
  a_code_le_win: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !chk_on_r) |-> out_code_value <= 34'(out_window_value))
    else $error("code exceeds window");

  // A zero digit count gives a zero code, with or without the check digit.
  a_zero_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && digits_r == 4'd0) |-> out_code_value == 34'd0)
    else $error("nonzero code for zero digits");

endmodule

bind hotp_code_from_digest hotp_checker u_checker (.*);

// File: bench/hotp_code_from_digest_tb.sv
`timescale 1ns / 1ps

module hotp_code_from_digest_tb;

  localparam int          RUN_LIMIT      = 200000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          RANDOM_PHASES  = 9;
  localparam logic [1:0]  CFG_UNUSED_IDX = 2'd3;
  localparam logic [4:0]  OFFSET_DYNAMIC = 5'h1F;
  localparam logic [4:0]  OFFSET_MOST_NEG = 5'h10;

  // One expected result: the code and the raw truncation window.
  typedef struct {
    logic [33:0] code;
    logic [30:0] window;
  } otp_result_t;

  // Predicts the code for each accepted digest and checks results in order.
  class otp_tracker;
    logic [3:0]  code_digits;
    logic        add_check;
    logic [4:0]  fixed_offset;
    otp_result_t pending_codes[$];
    int          errors;

    function new();
      code_digits  = 4'd6;
      add_check    = 1'b0;
      fixed_offset = OFFSET_DYNAMIC;
      errors       = 0;
    endfunction

    // A register write updates the local copy; unknown indexes change nothing.
    function void write_reg(logic [1:0] idx, logic [4:0] data);
      case (idx)
        hotp_pkg::CFG_CODE_DIGITS:  code_digits  = data[3:0];
        hotp_pkg::CFG_ADD_CHECK:    add_check    = data[0];
        hotp_pkg::CFG_FIXED_OFFSET: fixed_offset = data;
        default: ;
      endcase
    endfunction

    // Check digit over the low digits, doubling the rightmost one first.
    function int unsigned check_digit(longint unsigned value, int unsigned digs);
      int unsigned     sum;
      int unsigned     d;
      longint unsigned v;
      sum = 0;
      v   = value;
      for (int unsigned k = 0; k < digs; k++) begin
        d = int'(v % 10);
        v = v / 10;
        if (k % 2 == 0) begin
          sum += (2 * d > 9) ? 2 * d - 9 : 2 * d;
        end else begin
          sum += d;
        end
      end
      sum = sum % 10;
      return (sum != 0) ? 10 - sum : 0;
    endfunction

    // Accepted digest transfer: compute the expected window and code.
    function void note_digest(logic [63:0] top, logic [63:0] mid, logic [31:0] bot);
      logic [159:0]    digest;
      logic [31:0]     win32;
      int unsigned     off;
      int unsigned     digs;
      longint unsigned modulus;
      longint unsigned otp;
      longint unsigned full_code;
      otp_result_t     res;
      digest = {top, mid, bot};
      if (fixed_offset[4]) begin
        off = digest[3:0];
      end else begin
        off = fixed_offset[3:0];
      end
      win32      = digest[159 - 8 * off -: 32];
      res.window = win32[30:0];
      digs       = (code_digits > 9) ? 9 : code_digits;
      modulus    = 1;
      repeat (digs) modulus = modulus * 10;
      otp = longint'(res.window) % modulus;
      if (add_check) begin
        full_code = otp * 10 + check_digit(otp, digs);
      end else begin
        full_code = otp;
      end
      res.code = full_code[33:0];
      pending_codes.push_back(res);
    endfunction

    // Result transfer: compare with the oldest expectation, field by field.
    function void check_result(logic [33:0] code, logic [30:0] window);
      otp_result_t exp_res;
      if (pending_codes.size() == 0) begin
        $display("%0t: result with nothing expected: code %0d window %0d",
                 $time, code, window);
        errors++;
        return;
      end
      exp_res = pending_codes.pop_front();
      if (code !== exp_res.code) begin
        $display("%0t: code mismatch: expected %0d actual %0d", $time, exp_res.code, code);
        errors++;
      end
      if (window !== exp_res.window) begin
        $display("%0t: window mismatch: expected %0d actual %0d",
                 $time, exp_res.window, window);
        errors++;
      end
    endfunction

    function int pending();
      return pending_codes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_digest_top;
  logic [63:0] in_digest_middle;
  logic [31:0] in_digest_bottom;
  logic        out_valid;
  logic [33:0] out_code_value;
  logic [30:0] out_window_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [4:0]  cfg_data;

  otp_tracker tracker = new();
  int         cycles;

  hotp_code_from_digest DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_digest_top    (in_digest_top),
    .in_digest_middle (in_digest_middle),
    .in_digest_bottom (in_digest_bottom),
    .out_valid        (out_valid),
    .out_code_value   (out_code_value),
    .out_window_value (out_window_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Run limit as a safety net against a hung block.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("hotp_code_from_digest_tb: errors");
      $finish;
    end
  end

  // Observe every transfer on the three channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        tracker.note_digest(in_digest_top, in_digest_middle, in_digest_bottom);
      end
      if (cfg_valid && cfg_ready) begin
        tracker.write_reg(cfg_index, cfg_data);
      end
      if (out_valid) begin
        tracker.check_result(out_code_value, out_window_value);
      end
    end
  end

  // Present one digest and hold it until the transfer happens.
  task automatic send_digest(logic [63:0] top, logic [63:0] mid, logic [31:0] bot);
    @(negedge clk);
    start            <= 1'b1;
    in_digest_top    <= top;
    in_digest_middle <= mid;
    in_digest_bottom <= bot;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random_digest();
    logic [63:0] top;
    logic [63:0] mid;
    logic [31:0] bot;
    top = {$urandom, $urandom};
    mid = {$urandom, $urandom};
    bot = $urandom;
    // Now and then push the window to a corner of the digest.
    case ($urandom_range(0, 7))
      0: bot[3:0] = 4'hF;
      1: bot[3:0] = 4'h0;
      2: top = '1;
      3: mid = '0;
      default: ;
    endcase
    send_digest(top, mid, bot);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Lower start and wait until every expected result has been checked.
  task automatic drain();
    idle_cycles(1);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [4:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write all three registers; spare data bits are random.
  task automatic set_config(logic [3:0] digits, logic check, logic [4:0] offset);
    write_cfg(hotp_pkg::CFG_CODE_DIGITS, {1'($urandom), digits});
    write_cfg(hotp_pkg::CFG_ADD_CHECK, {4'($urandom), check});
    write_cfg(hotp_pkg::CFG_FIXED_OFFSET, offset);
  endtask

  // Random traffic in bursts with random gaps, occasionally pausing until empty.
  task automatic random_traffic(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat (burst) begin
        if (sent < count) begin
          send_random_digest();
          sent++;
        end
      end
      if ($urandom_range(0, 15) == 0) begin
        drain();
      end else if ($urandom_range(0, 2) != 0) begin
        idle_cycles($urandom_range(1, 9));
      end
    end
  endtask

  initial begin
    logic [63:0] top;
    logic [63:0] mid;
    logic [31:0] bot;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_digest_top    = '0;
    in_digest_middle = '0;
    in_digest_bottom = '0;
    cfg_valid        = 1'b0;
    cfg_index        = hotp_pkg::CFG_CODE_DIGITS;
    cfg_data         = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings, all-zero and all-one digests, every dynamic offset.
    send_digest('0, '0, '0);
    send_digest('1, '1, '1);
    for (int k = 0; k < 16; k++) begin
      top = {$urandom, $urandom};
      mid = {$urandom, $urandom};
      bot = {$urandom} & ~32'hF | 32'(k);
      send_digest(top, mid, bot);
    end
    drain();

    // Directed: nine digits with check digit at the last fixed offset.
    set_config(4'd9, 1'b1, 5'd15);
    send_digest('1, '1, '1);
    send_digest('0, '0, '0);
    send_digest('0, 64'h0000_0000_0000_007F, 32'hFFFF_FF00);
    drain();

    // Directed: zero digits, first fixed offset, and a write to an unused index.
    set_config(4'd0, 1'b1, 5'd0);
    write_cfg(CFG_UNUSED_IDX, 5'($urandom));
    send_digest('1, '0, '0);
    send_digest(64'h7FFF_FFFF_0000_0000, '0, '0);
    drain();

    // Random phases over a range of settings, the extremes first.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config(4'd1, 1'b0, 5'd0);
        1: set_config(4'd9, 1'b1, OFFSET_DYNAMIC);
        2: set_config(4'd0, 1'b0, 5'd15);
        3: set_config(4'd15, 1'b1, OFFSET_MOST_NEG);
        4: set_config(4'd10, 1'b0, 5'($urandom_range(0, 15)));
        default: set_config(4'($urandom_range(0, 15)), 1'($urandom), 5'($urandom));
      endcase
      random_traffic($urandom_range(40, 60));
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("hotp_code_from_digest_tb: clean");
    end else begin
      $display("hotp_code_from_digest_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/hotp_pkg.sv
hw/rtl/hotp_window.sv
hw/rtl/hotp_bcd.sv
hw/rtl/hotp_code.sv
hw/rtl/hotp_code_from_digest.sv
hw/rtl/hotp_checker.sv
bench/hotp_code_from_digest_tb.sv
